// File: rtl/core/bf3h_pkg.sv
// Shared types and constants of the three-hash Bloom filter.
package bf3h_pkg;

   localparam int HASH_W          = 64;
   localparam int NUM_HASH        = 3;
   localparam int WORD_BITS       = 32;
   localparam int WORD_SHIFT      = $clog2(WORD_BITS);
   localparam int FILTER_BITS_DEF = 65536;
   localparam int MOD_STEP_BITS   = 4;

   localparam logic [31:0]       FNV_MULT = 32'h811C9DC5;
   localparam logic [31:0]       RS_STEP  = 32'd378551;
   localparam logic [31:0]       RS_START = 32'd63689;
   localparam logic [HASH_W-1:0] JS_START = 64'd1315423911;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD_START,
      ST_MOD_WAIT,
      ST_READ,
      ST_READ_TAIL,
      ST_WRITE,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic step;
      logic last;
   } hash_cmd_type;

endpackage

// File: rtl/core/bf3h_hash.sv
// Running FNV-style, RS and JS hashes over the key bytes.
module bf3h_hash
   import bf3h_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  hash_cmd_type                     cmd,
   input  logic [7:0]                       key_byte,
   output logic [NUM_HASH-1:0][HASH_W-1:0]  hash_val
);

   logic [HASH_W-1:0] fnv_ff, rs_ff, js_ff;
   logic [31:0]       mult_ff;
   logic              busy_ff, last_ff;
   logic [7:0]        byte_ff;
   logic [HASH_W-1:0] pf_lo_ff, pr_lo_ff;
   logic [31:0]       pf_hi_ff, pr_hi_ff;
   logic [NUM_HASH-1:0][HASH_W-1:0] res_ff;

   logic [HASH_W-1:0] fnv_in, rs_in, js_in;
   logic [HASH_W-1:0] pf_lo_in, pr_lo_in, pf_hi_full, pr_hi_full;
   logic [31:0]       mult_in;

   always_comb begin
      pf_lo_in   = {32'b0, fnv_ff[31:0]} * {32'b0, FNV_MULT};
      pf_hi_full = {32'b0, fnv_ff[63:32]} * {32'b0, FNV_MULT};
      pr_lo_in   = {32'b0, rs_ff[31:0]} * {32'b0, mult_ff};
      pr_hi_full = {32'b0, rs_ff[63:32]} * {32'b0, mult_ff};
      mult_in    = mult_ff * RS_STEP;
      js_in      = js_ff ^ ((js_ff << 5) + {56'b0, key_byte} + (js_ff >> 2));
      fnv_in     = (pf_lo_ff + {pf_hi_ff, 32'b0}) ^ {56'b0, byte_ff};
      rs_in      = pr_lo_ff + {pr_hi_ff, 32'b0} + {56'b0, byte_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fnv_ff  <= '0;
         rs_ff   <= '0;
         mult_ff <= RS_START;
         js_ff   <= JS_START;
         busy_ff <= 1'b0;
      end else if (cmd.step) begin
         mult_ff <= mult_in;
         js_ff   <= js_in;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         busy_ff <= 1'b0;
         if (last_ff) begin
            fnv_ff  <= '0;
            rs_ff   <= '0;
            mult_ff <= RS_START;
            js_ff   <= JS_START;
         end else begin
            fnv_ff <= fnv_in;
            rs_ff  <= rs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         pf_lo_ff <= pf_lo_in;
         pf_hi_ff <= pf_hi_full[31:0];
         pr_lo_ff <= pr_lo_in;
         pr_hi_ff <= pr_hi_full[31:0];
         byte_ff  <= key_byte;
         last_ff  <= cmd.last;
      end
      if (busy_ff && last_ff) begin
         res_ff[0] <= fnv_in;
         res_ff[1] <= rs_in;
         res_ff[2] <= js_ff;
      end
   end

   assign hash_val = res_ff;

endmodule

// File: rtl/core/bf3h_mod.sv
// Reduction of the three final hashes modulo the filter size.
module bf3h_mod
   import bf3h_pkg::*;
#(
   parameter int FILTER_BITS = FILTER_BITS_DEF,
   parameter int IDX_W       = $clog2(FILTER_BITS_DEF)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [NUM_HASH-1:0][HASH_W-1:0]  vals,
   output logic                             done,
   output logic [NUM_HASH-1:0][IDX_W-1:0]   idx
);

   if ((FILTER_BITS & (FILTER_BITS - 1)) == 0) begin : g_pow2
      logic                           done_ff;
      logic [NUM_HASH-1:0][IDX_W-1:0] idx_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b0;
         end else begin
            done_ff <= start;
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            for (int l = 0; l < NUM_HASH; l++) begin
               idx_ff[l] <= vals[l][IDX_W-1:0];
            end
         end
      end

      assign done = done_ff;
      assign idx  = idx_ff;
   end else begin : g_serial
      localparam int RW    = IDX_W + 1;
      localparam int STEPS = HASH_W / MOD_STEP_BITS;
      localparam int CW    = $clog2(STEPS);

      logic                            busy_ff, done_ff;
      logic [CW-1:0]                   cnt_ff;
      logic [NUM_HASH-1:0][HASH_W-1:0] val_ff;
      logic [NUM_HASH-1:0][IDX_W-1:0]  rem_ff, rem_in;

      always_comb begin
         logic [RW-1:0] r;
         r = '0;
         for (int l = 0; l < NUM_HASH; l++) begin
            r = {1'b0, rem_ff[l]};
            for (int s = 0; s < MOD_STEP_BITS; s++) begin
               r = {r[IDX_W-1:0], val_ff[l][HASH_W-1-s]};
               if (r >= RW'(FILTER_BITS)) begin
                  r = r - RW'(FILTER_BITS);
               end
            end
            rem_in[l] = r[IDX_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b0;
            cnt_ff  <= '0;
         end else begin
            done_ff <= 1'b0;
            if (start) begin
               busy_ff <= 1'b1;
               cnt_ff  <= '0;
            end else if (busy_ff) begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(STEPS - 1)) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            val_ff <= vals;
            rem_ff <= '0;
         end else if (busy_ff) begin
            for (int l = 0; l < NUM_HASH; l++) begin
               val_ff[l] <= val_ff[l] << MOD_STEP_BITS;
            end
            rem_ff <= rem_in;
         end
      end

      assign done = done_ff;
      assign idx  = rem_ff;
   end

endmodule

// File: rtl/core/bf3h_mem.sv
// Single-port filter bit store, one word per row, registered read.
module bf3h_mem
   import bf3h_pkg::*;
#(
   parameter int ROWS = FILTER_BITS_DEF / WORD_BITS,
   parameter int AW   = $clog2(FILTER_BITS_DEF / WORD_BITS)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        addr,
   input  logic [WORD_BITS-1:0] wdata,
   output logic [WORD_BITS-1:0] rdata
);

   logic [WORD_BITS-1:0] row_mem [ROWS];
   logic [WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         row_mem[addr] <= wdata;
      end
      rdata_ff <= row_mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/bf3h_ctrl.sv
// Sequencer: store clearing, byte handshake, bit reads and writes, result register.
module bf3h_ctrl
   import bf3h_pkg::*;
#(
   parameter int ROWS  = FILTER_BITS_DEF / WORD_BITS,
   parameter int AW    = $clog2(FILTER_BITS_DEF / WORD_BITS),
   parameter int IDX_W = $clog2(FILTER_BITS_DEF)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic                           req_last,
   output hash_cmd_type                   hash_cmd,
   output logic                           mod_start,
   input  logic                           mod_done,
   input  logic [NUM_HASH-1:0][IDX_W-1:0] idx,
   output logic                           mem_we,
   output logic [AW-1:0]                  mem_addr,
   output logic [WORD_BITS-1:0]           mem_wdata,
   input  logic [WORD_BITS-1:0]           mem_rdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_member,
   output logic                           rsp_op_was_insert
);

   ctrl_state_type state_ff, state_in;
   logic [AW-1:0]  cnt_ff, cnt_in;
   logic [1:0]     sel_ff, sel_in, rd_sel_ff;
   logic           rd_valid_ff, rd_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_member_ff, rsp_ins_ff;
   logic           func_ff, last_ff;
   logic           load_rsp;
   logic [NUM_HASH-1:0][WORD_BITS-1:0] row_data_ff;

   logic [NUM_HASH-1:0][AW-1:0]         row;
   logic [NUM_HASH-1:0][WORD_SHIFT-1:0] bitpos;
   logic [NUM_HASH-1:0][WORD_BITS-1:0]  mask;
   logic [WORD_BITS-1:0]                wr_word;
   logic                                hit;

   always_comb begin
      hit = 1'b1;
      for (int k = 0; k < NUM_HASH; k++) begin
         row[k]    = AW'(idx[k] >> WORD_SHIFT);
         bitpos[k] = idx[k][WORD_SHIFT-1:0];
         mask[k]   = WORD_BITS'(1) << bitpos[k];
         hit       = hit & row_data_ff[k][bitpos[k]];
      end
      wr_word = row_data_ff[sel_ff];
      for (int j = 0; j < NUM_HASH; j++) begin
         if (row[j] == row[sel_ff]) begin
            wr_word = wr_word | mask[j];
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      sel_in      = sel_ff;
      req_ready   = 1'b0;
      mod_start   = 1'b0;
      mem_we      = 1'b0;
      mem_addr    = row[sel_ff];
      mem_wdata   = wr_word;
      rd_valid_in = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = cnt_ff;
            mem_wdata = '0;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == AW'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            state_in = last_ff ? ST_MOD_START : ST_IDLE;
         end
         ST_MOD_START: begin
            mod_start = 1'b1;
            state_in  = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            sel_in = '0;
            if (mod_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_valid_in = 1'b1;
            if (sel_ff == 2'(NUM_HASH - 1)) begin
               sel_in   = '0;
               state_in = ST_READ_TAIL;
            end else begin
               sel_in = sel_ff + 1'b1;
            end
         end
         ST_READ_TAIL: begin
            state_in = (func_ff == FUNC_INSERT) ? ST_WRITE : ST_DONE;
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            if (sel_ff == 2'(NUM_HASH - 1)) begin
               sel_in   = '0;
               state_in = ST_DONE;
            end else begin
               sel_in = sel_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         sel_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_sel_ff <= sel_ff;
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         last_ff <= req_last;
      end
      if (rd_valid_ff) begin
         row_data_ff[rd_sel_ff] <= mem_rdata;
      end
      if (load_rsp) begin
         rsp_member_ff <= hit;
         rsp_ins_ff    <= (func_ff == FUNC_INSERT);
      end
   end

   assign hash_cmd.step     = req_valid & req_ready;
   assign hash_cmd.last     = req_last;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_member        = rsp_member_ff;
   assign rsp_op_was_insert = rsp_ins_ff;

endmodule

// File: rtl/core/bloom_filter_three_hash_top.sv
// Top level of the three-hash Bloom filter over byte-serial keys.
//
// Key bytes enter on the req_ channel, one transaction per byte, with req_last on the
// final byte; req_func of the final byte selects insert or lookup. For each key byte
// the hash multiplies run as registered 32-bit partial products before the accumulate.
// After the final byte the three hashes are reduced to bit indices (the low bits for
// a power-of-two FILTER_BITS, otherwise a serial reduction of 4 bits per cycle), then
// the single-port bit store is read three times and, for an insert, written three
// times. One rsp_ transaction is produced per key. The result register holds a
// finished transaction while the next key's bytes are hashed; the block only waits
// when a new result is ready and the old one has not been taken. After reset the
// store is cleared one 32-bit row per cycle, with req_ready low.
module bloom_filter_three_hash_top
   import bf3h_pkg::*;
#(
   parameter int FILTER_BITS = FILTER_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_key_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_member,
   output logic       rsp_op_was_insert
);

   localparam int IDX_W = $clog2(FILTER_BITS);
   localparam int ROWS  = (FILTER_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = $clog2(ROWS);

   hash_cmd_type                    hash_cmd;
   logic [NUM_HASH-1:0][HASH_W-1:0] hash_val;
   logic                            mod_start, mod_done;
   logic [NUM_HASH-1:0][IDX_W-1:0]  idx;
   logic                            mem_we;
   logic [AW-1:0]                   mem_addr;
   logic [WORD_BITS-1:0]            mem_wdata, mem_rdata;

   bf3h_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .cmd      (hash_cmd),
      .key_byte (req_key_byte),
      .hash_val (hash_val)
   );

   bf3h_mod #(
      .FILTER_BITS (FILTER_BITS),
      .IDX_W       (IDX_W)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .vals  (hash_val),
      .done  (mod_done),
      .idx   (idx)
   );

   bf3h_mem #(
      .ROWS (ROWS),
      .AW   (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   bf3h_ctrl #(
      .ROWS  (ROWS),
      .AW    (AW),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_last          (req_last),
      .hash_cmd          (hash_cmd),
      .mod_start         (mod_start),
      .mod_done          (mod_done),
      .idx               (idx),
      .mem_we            (mem_we),
      .mem_addr          (mem_addr),
      .mem_wdata         (mem_wdata),
      .mem_rdata         (mem_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_member        (rsp_member),
      .rsp_op_was_insert (rsp_op_was_insert)
   );

   a_step_two_cycles: assert property (@(posedge clock) disable iff (reset)
      hash_cmd.step |=> !req_ready)
      else $error("A key byte was accepted while the hash step was in progress.");

   a_no_accept_on_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !req_ready)
      else $error("The bit store was written while a key byte could be accepted.");

   a_no_accept_on_reduce: assert property (@(posedge clock) disable iff (reset)
      mod_start |-> !req_ready && !hash_cmd.step)
      else $error("A key byte was accepted while the hashes were being reduced.");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the three-hash Bloom filter over byte-serial keys.
`timescale 1ns / 1ps

module testbench
   import bf3h_pkg::*;
();

   localparam int FILTER_BITS  = FILTER_BITS_DEF;
   localparam int RANDOM_BYTES = 1750;
   localparam int HOLD_CYCLES  = 600;
   localparam int HOLD_AT      = 40;
   localparam int DRAIN_CYCLES = 60;
   localparam int LIMIT        = 500000;
   localparam int MAX_KEY      = 24;

   typedef struct packed {
      logic [63:0] fnv;
      logic [63:0] rs;
      logic [31:0] mult;
      logic [63:0] js;
   } hash_state_type;

   typedef struct packed {
      logic member;
      logic op_was_insert;
   } rsp_item_type;

   typedef struct packed {
      logic [MAX_KEY*8-1:0] bytes;
      logic [4:0]           len;
   } key_type;

   class scoreboard_type;
      hash_state_type acc;
      bit             filter_bits[FILTER_BITS];
      rsp_item_type   pending_results[$];
      int             errors;

      function new();
         acc    = fresh_state();
         errors = 0;
      endfunction

      function hash_state_type fresh_state();
         hash_state_type s;
         s.fnv  = '0;
         s.rs   = '0;
         s.mult = RS_START;
         s.js   = JS_START;
         return s;
      endfunction

      function hash_state_type mix(hash_state_type s, logic [7:0] b);
         hash_state_type n;
         n.fnv  = (s.fnv * 64'(FNV_MULT)) ^ 64'(b);
         n.rs   = s.rs * 64'(s.mult) + 64'(b);
         n.mult = s.mult * RS_STEP;
         n.js   = s.js ^ ((s.js << 5) + 64'(b) + (s.js >> 2));
         return n;
      endfunction

      function int unsigned slot(logic [63:0] h);
         logic [63:0] r;
         r = h % 64'(FILTER_BITS);
         return int'(r);
      endfunction

      function void note_byte(logic func, logic [7:0] b, logic last);
         int unsigned  i1, i2, i3;
         rsp_item_type r;
         acc = mix(acc, b);
         if (last) begin
            i1 = slot(acc.fnv);
            i2 = slot(acc.rs);
            i3 = slot(acc.js);
            r.member        = filter_bits[i1] && filter_bits[i2] && filter_bits[i3];
            r.op_was_insert = (func == FUNC_INSERT);
            if (func == FUNC_INSERT) begin
               filter_bits[i1] = 1'b1;
               filter_bits[i2] = 1'b1;
               filter_bits[i3] = 1'b1;
            end
            pending_results.push_back(r);
            acc = fresh_state();
         end
      endfunction

      function void check_result(logic member, logic op_was_insert);
         rsp_item_type e;
         if (pending_results.size() == 0) begin
            $error("unexpected rsp transaction: member %0d op_was_insert %0d",
                   member, op_was_insert);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         if (member !== e.member) begin
            $error("member: expected %0d, actual %0d", e.member, member);
            errors++;
         end
         if (op_was_insert !== e.op_was_insert) begin
            $error("op_was_insert: expected %0d, actual %0d", e.op_was_insert, op_was_insert);
            errors++;
         end
      endfunction

      // Finds a three-byte key for which two of the hashes land on the same bit.
      function key_type find_colliding_key();
         key_type        k;
         hash_state_type s;
         int unsigned    a, b, c;
         k = '0;
         for (int n = 0; n < (1 << 24); n++) begin
            s = fresh_state();
            for (int i = 0; i < 3; i++) s = mix(s, 8'(n >> (8 * i)));
            a = slot(s.fnv);
            b = slot(s.rs);
            c = slot(s.js);
            if (a == b || a == c || b == c) begin
               k.bytes[23:0] = 24'(n);
               k.len         = 5'd3;
               return k;
            end
         end
         return k;
      endfunction
   endclass

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_func      = 1'b0;
   logic [7:0] req_key_byte  = 8'h00;
   logic       req_last      = 1'b0;
   logic       rsp_ready     = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_member;
   logic       rsp_op_was_insert;

   scoreboard_type sb;
   key_type        key_pool[$];
   bit             no_idle = 1'b0;
   int             cycles  = 0;

   bloom_filter_three_hash_top #(
      .FILTER_BITS(FILTER_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_key_byte     (req_key_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_member       (rsp_member),
      .rsp_op_was_insert(rsp_op_was_insert)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("bloom_filter_three_hash_top verification failed");
         $finish;
      end
   end

   // Results are checked before the same edge's input is noted, so that a
   // result never matches an expectation created at that edge.
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_member, rsp_op_was_insert);
         if (req_valid && req_ready) sb.note_byte(req_func, req_key_byte, req_last);
      end
   end

   task automatic send_byte(logic func, logic [7:0] b, logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_key_byte <= b;
      req_last     <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_key(key_type k, logic final_func, logic early_func);
      for (int i = 0; i < k.len; i++) begin
         send_byte((i == k.len - 1) ? final_func : early_func, k.bytes[i*8 +: 8],
                   i == k.len - 1);
      end
      if (final_func == FUNC_INSERT) key_pool.push_back(k);
   endtask

   initial begin : rsp_side
      int wait_cycles;
      int taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AT) wait_cycles = HOLD_CYCLES;
         else wait_cycles = no_idle ? 0 : $urandom_range(0, 15);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin : stimulus
      key_type k;
      logic    fin_func;
      int      rand_bytes;
      int      key_count;
      int      pick;
      sb = new();
      rand_bytes = 0;
      key_count  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      k = '0;
      k.len = 5'd1;
      send_key(k, FUNC_LOOKUP, FUNC_LOOKUP);
      send_key(k, FUNC_INSERT, FUNC_INSERT);
      send_key(k, FUNC_LOOKUP, FUNC_LOOKUP);
      send_key(k, FUNC_INSERT, FUNC_INSERT);
      k.bytes[7:0] = 8'hFF;
      send_key(k, FUNC_INSERT, FUNC_INSERT);
      k.bytes[23:0] = 24'hA500FF;
      k.len = 5'd3;
      send_key(k, FUNC_INSERT, FUNC_LOOKUP);
      send_key(k, FUNC_LOOKUP, FUNC_INSERT);
      k.bytes[63:0] = '1;
      k.len = 5'd8;
      send_key(k, FUNC_INSERT, FUNC_LOOKUP);
      k = sb.find_colliding_key();
      if (k.len != 0) begin
         send_key(k, FUNC_INSERT, FUNC_LOOKUP);
         send_key(k, FUNC_LOOKUP, FUNC_INSERT);
      end

      while (rand_bytes < RANDOM_BYTES) begin
         if (key_count % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         key_count++;
         if (key_pool.size() != 0 && $urandom_range(0, 9) < 4) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            fin_func = ($urandom_range(0, 9) < 7) ? FUNC_LOOKUP : FUNC_INSERT;
         end else begin
            k = '0;
            k.len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(7, MAX_KEY))
                                                : 5'($urandom_range(1, 6));
            for (int i = 0; i < k.len; i++) begin
               pick = $urandom_range(0, 9);
               k.bytes[i*8 +: 8] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            end
            fin_func = 1'($urandom_range(0, 1));
         end
         send_key(k, fin_func, 1'($urandom_range(0, 1)));
         rand_bytes += k.len;
      end
      req_valid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         $error("%0d expected rsp transactions never arrived", sb.pending_results.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("bloom_filter_three_hash_top verification clean");
      end else begin
         $display("bloom_filter_three_hash_top verification failed");
      end
      $finish;
   end

endmodule
